@@ hdl/wpo_pkg.sv @@
// ============================================================================
// wpo_pkg
// Shared constants and types for the wavetable / pulse-width oscillator.
// ============================================================================
`default_nettype none

package wpo_pkg;

    localparam int TABLE_BITS_DEF  = 10;
    localparam int NUM_TABLES_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PHASE_W = 32;
    localparam int VALUE_W = 16;
    localparam int AMP_W   = 16;
    localparam int WAVE_W  = 3;
    localparam int INDEX_W = 10;
    localparam int TSEL_W  = 2;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd80530637;
    localparam logic [WAVE_W-1:0]  WAVEFORM_RST    = 3'd0;
    localparam logic [PHASE_W-1:0] PULSE_WIDTH_RST = 32'h8000_0000;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 16'h8000;

    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd4;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_WAVEFORM    = 2'd1,
        REG_PULSE_WIDTH = 2'd2,
        REG_AMPLITUDE   = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

@@ hdl/wpo_wave_ram.sv @@
// ============================================================================
// wpo_wave_ram
// Wave table store: one write port, one registered read port with enable.
// ============================================================================
`default_nettype none

module wpo_wave_ram #(
    parameter int DEPTH  = wpo_pkg::NUM_TABLES_DEF << wpo_pkg::TABLE_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [wpo_pkg::VALUE_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    output      logic [wpo_pkg::VALUE_W-1:0]  rd_data
);

    logic [wpo_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/wavetable_pwm_oscillator_unit.sv @@
// ============================================================================
// wavetable_pwm_oscillator_unit
// Phase-accumulator oscillator: wave table or pulse-width square, Q1.15 gain.
// ============================================================================
// A tick item's sample passes the table read register and then the result register; loads give none.
// Throughput: one item per cycle; the table read and the gain multiply are
// separate register stages, so req_ready falls only when both are full and
// the output is stalled.
// Reset: phase cleared, registers to their defaults; tables are not cleared
// and read undefined until loaded.
`default_nettype none

module wavetable_pwm_oscillator_unit #(
    parameter int TABLE_BITS  = wpo_pkg::TABLE_BITS_DEF,
    parameter int NUM_TABLES  = wpo_pkg::NUM_TABLES_DEF,
    parameter int SAMPLE_BITS = wpo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready,

    input  wire logic                          req_valid,
    output      logic                          req_ready,
    input  wire logic                          action,
    input  wire logic [wpo_pkg::TSEL_W-1:0]    table_select,
    input  wire logic [wpo_pkg::INDEX_W-1:0]   entry_index,
    input  wire logic signed [wpo_pkg::VALUE_W-1:0] entry_value,

    output      logic                          rsp_valid,
    input  wire logic                          rsp_ready,
    output      logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int DEPTH  = NUM_TABLES << TABLE_BITS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (TABLE_BITS > wpo_pkg::INDEX_W) ? TABLE_BITS : wpo_pkg::INDEX_W;
    localparam int OP_W   = (SAMPLE_BITS + 1 > wpo_pkg::VALUE_W + 1) ?
                            SAMPLE_BITS + 1 : wpo_pkg::VALUE_W + 1;
    localparam int GAIN_W = wpo_pkg::AMP_W + 1;
    localparam int PROD_W = OP_W + GAIN_W;

    localparam logic signed [OP_W-1:0]   FULL_SCALE = OP_W'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) << (SAMPLE_BITS - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -(PROD_W'(1) << (SAMPLE_BITS - 1));

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_TABLE,
        KIND_SQUARE
    } kind_t;

    // configuration registers
    logic [wpo_pkg::PHASE_W-1:0] phase_step_reg;
    logic [wpo_pkg::WAVE_W-1:0]  waveform_reg;
    logic [wpo_pkg::PHASE_W-1:0] pulse_width_reg;
    logic [wpo_pkg::AMP_W-1:0]   amplitude_reg;

    logic                   cfg_wr;
    wpo_pkg::reg_idx_t      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = wpo_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= wpo_pkg::PHASE_STEP_RST;
            waveform_reg    <= wpo_pkg::WAVEFORM_RST;
            pulse_width_reg <= wpo_pkg::PULSE_WIDTH_RST;
            amplitude_reg   <= wpo_pkg::AMPLITUDE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                wpo_pkg::REG_PHASE_STEP:  phase_step_reg  <= pwdata;
                wpo_pkg::REG_WAVEFORM:    waveform_reg    <= pwdata[wpo_pkg::WAVE_W-1:0];
                wpo_pkg::REG_PULSE_WIDTH: pulse_width_reg <= pwdata;
                wpo_pkg::REG_AMPLITUDE:   amplitude_reg   <= pwdata[wpo_pkg::AMP_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            wpo_pkg::REG_PHASE_STEP:  prdata = phase_step_reg;
            wpo_pkg::REG_WAVEFORM:    prdata = 32'(waveform_reg);
            wpo_pkg::REG_PULSE_WIDTH: prdata = pulse_width_reg;
            wpo_pkg::REG_AMPLITUDE:   prdata = 32'(amplitude_reg);
            default:                  prdata = '0;
        endcase
    end

    // handshake
    logic s1_valid_reg;
    logic rsp_valid_reg;
    logic out_free;
    logic accept;
    logic tick_acc;
    logic load_acc;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;
    assign tick_acc  = accept && (action == wpo_pkg::ACT_TICK);
    assign load_acc  = accept && (action == wpo_pkg::ACT_LOAD);

    // phase accumulator and tick decode
    logic [wpo_pkg::PHASE_W-1:0] phase_reg;
    logic [wpo_pkg::PHASE_W-1:0] phase_next;
    logic                        table_ok;
    kind_t                       kind_next;

    assign phase_next = phase_reg + phase_step_reg;
    assign table_ok   = !waveform_reg[wpo_pkg::WAVE_W-1] &&
                        (32'(waveform_reg) < 32'(NUM_TABLES));

    always_comb
    begin
        priority if (waveform_reg == wpo_pkg::WAVE_SQUARE)
            kind_next = KIND_SQUARE;
        else if (table_ok)
            kind_next = KIND_TABLE;
        else
            kind_next = KIND_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (tick_acc)
        begin
            phase_reg <= phase_next;
        end
    end

    // table store
    logic [IDX_W-1:0]            idx_ext;
    logic [TABLE_BITS-1:0]       wr_idx;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [wpo_pkg::VALUE_W-1:0] rd_data;

    assign idx_ext = IDX_W'(entry_index);
    assign wr_idx  = idx_ext[TABLE_BITS-1:0];
    assign wr_en   = load_acc && (32'(table_select) < 32'(NUM_TABLES));
    assign wr_addr = ADDR_W'((32'(table_select) << TABLE_BITS) | 32'(wr_idx));
    assign rd_addr = ADDR_W'((32'(waveform_reg) << TABLE_BITS) |
                             32'(phase_reg[wpo_pkg::PHASE_W-1 -: TABLE_BITS]));

    wpo_wave_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_wave_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_en   (tick_acc && table_ok),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stage 1: table word or square level, then gain
    kind_t s1_kind_reg;
    logic  s1_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= tick_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s1_kind_reg <= kind_next;
            s1_neg_reg  <= phase_reg < pulse_width_reg;
        end
    end

    logic signed [OP_W-1:0]        operand;
    logic signed [GAIN_W-1:0]      gain;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      scaled;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    assign gain   = $signed({1'b0, amplitude_reg});
    assign prod   = PROD_W'(operand) * PROD_W'(gain);
    assign scaled = prod >>> 15;

    always_comb
    begin
        unique case (s1_kind_reg)
            KIND_SQUARE: operand = s1_neg_reg ? -FULL_SCALE : FULL_SCALE;
            KIND_TABLE:  operand = OP_W'($signed(rd_data));
            default:     operand = '0;
        endcase
    end

    always_comb
    begin
        priority if (scaled > SAT_HI)
            sample_next = SAT_HI[SAMPLE_BITS-1:0];
        else if (scaled < SAT_LO)
            sample_next = SAT_LO[SAMPLE_BITS-1:0];
        else
            sample_next = scaled[SAMPLE_BITS-1:0];
    end

    // result register
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
        begin
            sample_reg <= sample_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign sample    = sample_reg;

    // checks
    a_phase_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc |=> phase_reg == $past(phase_reg + phase_step_reg))
        else $error("phase did not advance by one step on a tick");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_acc |=> $stable(phase_reg))
        else $error("phase moved without a tick");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && rsp_valid_reg && $stable(sample_reg))
        else $error("pending item lost under output stall");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> !s1_valid_reg || $past(s1_valid_reg && !out_free))
        else $error("load item produced a result");

endmodule

`default_nettype wire

@@ bench/tb_wavetable_pwm_oscillator_unit.sv @@
// ============================================================================
// tb_wavetable_pwm_oscillator_unit
// Self-checking bench for the wavetable / pulse-width oscillator. Items go in
// on a valid/ready channel and registers are set over APB. A cycle-free
// predictor tracks the phase, registers and table words, and each returned
// sample is checked in order against it. Directed cases cover the table and
// square modes, gain saturation, phase wrap and unused waveform codes, then
// randomised traffic runs under varying handshake stalls.
// ============================================================================

module tb_wavetable_pwm_oscillator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TABLE_LEN      = 1 << wpo_pkg::TABLE_BITS_DEF;
    localparam int     IDX_LSB        = wpo_pkg::PHASE_W - wpo_pkg::TABLE_BITS_DEF;
    localparam longint FULL_SCALE     = longint'(1) << (wpo_pkg::SAMPLE_BITS_DEF - 1);
    localparam longint SAMPLE_MAX     = FULL_SCALE - 1;
    localparam longint SAMPLE_MIN     = -FULL_SCALE;
    localparam int     SETTLE_CYCLES  = 6;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RANDOM_BLOCKS  = 8;
    localparam int     BLOCK_ITEMS    = 65;

    logic clk = 1'b0;
    logic rst_n;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic                                 req_valid;
    logic                                 req_ready;
    logic                                 action;
    logic [wpo_pkg::TSEL_W-1:0]           table_select;
    logic [wpo_pkg::INDEX_W-1:0]          entry_index;
    logic signed [wpo_pkg::VALUE_W-1:0]   entry_value;

    logic                                 rsp_valid;
    logic                                 rsp_ready = 1'b0;
    logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] sample;

    // predictor state
    logic [wpo_pkg::PHASE_W-1:0]        osc_step;
    logic [wpo_pkg::WAVE_W-1:0]         osc_wave;
    logic [wpo_pkg::PHASE_W-1:0]        osc_pw;
    logic [wpo_pkg::AMP_W-1:0]          osc_gain;
    logic [wpo_pkg::PHASE_W-1:0]        osc_phase;
    logic signed [wpo_pkg::VALUE_W-1:0] wave_mem [wpo_pkg::NUM_TABLES_DEF][TABLE_LEN];
    bit                                 wave_set [wpo_pkg::NUM_TABLES_DEF][TABLE_LEN];

    logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] sample_due_q [$];
    logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] sample_want;

    int err_cnt      = 0;
    int items_sent   = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    wavetable_pwm_oscillator_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .action       (action),
        .table_select (table_select),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .sample       (sample)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] scale_gain(
        input longint level);
        longint q;
        q = (level * longint'(osc_gain)) >>> 15;
        if (q > SAMPLE_MAX)
        begin
            q = SAMPLE_MAX;
        end
        else if (q < SAMPLE_MIN)
        begin
            q = SAMPLE_MIN;
        end
        return q[wpo_pkg::SAMPLE_BITS_DEF-1:0];
    endfunction

    function automatic logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] osc_next_sample();
        logic signed [wpo_pkg::SAMPLE_BITS_DEF-1:0] s;
        s = '0;
        if (osc_wave == wpo_pkg::WAVE_SQUARE)
        begin
            s = scale_gain((osc_phase < osc_pw) ? -FULL_SCALE : FULL_SCALE);
        end
        else if (osc_wave < wpo_pkg::WAVE_SQUARE && osc_wave < wpo_pkg::NUM_TABLES_DEF)
        begin
            s = scale_gain(longint'(wave_mem[osc_wave[wpo_pkg::TSEL_W-1:0]]
                                            [osc_phase[wpo_pkg::PHASE_W-1:IDX_LSB]]));
        end
        osc_phase = osc_phase + osc_step;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // result side: ready pattern, checking, watchdog
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (sample_due_q.size() == 0)
            begin
                $display("%0t: unexpected sample %0d, none expected", $time, sample);
                err_cnt++;
            end
            else
            begin
                sample_want = sample_due_q.pop_front();
                if (sample !== sample_want)
                begin
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, sample_want, sample);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
            || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // item and register access
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [wpo_pkg::TSEL_W-1:0] tsel,
                             input logic [wpo_pkg::INDEX_W-1:0] idx,
                             input logic signed [wpo_pkg::VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        action       <= act;
        table_select <= tsel;
        entry_index  <= idx;
        entry_value  <= val;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        if (act == wpo_pkg::ACT_LOAD)
        begin
            if (tsel < wpo_pkg::NUM_TABLES_DEF)
            begin
                wave_mem[tsel][idx] = val;
                wave_set[tsel][idx] = 1'b1;
            end
        end
        else
        begin
            sample_due_q.push_back(osc_next_sample());
        end
        items_sent++;
        @(negedge clk);
    endtask

    // a tick never reads a table word that was not loaded: fill it first
    task automatic play_tick();
        logic [wpo_pkg::INDEX_W-1:0] idx;
        idx = osc_phase[wpo_pkg::PHASE_W-1:IDX_LSB];
        if (osc_wave < wpo_pkg::WAVE_SQUARE && osc_wave < wpo_pkg::NUM_TABLES_DEF
            && !wave_set[osc_wave[wpo_pkg::TSEL_W-1:0]][idx])
        begin
            send_item(wpo_pkg::ACT_LOAD, osc_wave[wpo_pkg::TSEL_W-1:0], idx, 16'($urandom));
        end
        send_item(wpo_pkg::ACT_TICK, 2'($urandom), 10'($urandom), 16'($urandom));
    endtask

    task automatic load_and_tick(input logic signed [wpo_pkg::VALUE_W-1:0] val);
        send_item(wpo_pkg::ACT_LOAD, osc_wave[wpo_pkg::TSEL_W-1:0],
                  osc_phase[wpo_pkg::PHASE_W-1:IDX_LSB], val);
        play_tick();
    endtask

    task automatic quiesce();
        req_valid <= 1'b0;
        while (sample_due_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_profile(input int send_pct, input int recv_pct);
        req_valid <= 1'b0;
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input wpo_pkg::reg_idx_t r,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {r, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input wpo_pkg::reg_idx_t r);
        logic [31:0] got;
        logic [31:0] want;
        apb_access(1'b0, r, 32'd0, got);
        case (r)
            wpo_pkg::REG_PHASE_STEP:  want = osc_step;
            wpo_pkg::REG_WAVEFORM:    want = 32'(osc_wave);
            wpo_pkg::REG_PULSE_WIDTH: want = osc_pw;
            default:                  want = 32'(osc_gain);
        endcase
        if (got !== want)
        begin
            $display("%0t: register %s readback, expected %0h actual %0h",
                     $time, r.name(), want, got);
            err_cnt++;
        end
    endtask

    task automatic write_reg(input wpo_pkg::reg_idx_t r, input logic [31:0] v);
        logic [31:0] unused_rd;
        quiesce();
        apb_access(1'b1, r, v, unused_rd);
        case (r)
            wpo_pkg::REG_PHASE_STEP:  osc_step = v;
            wpo_pkg::REG_WAVEFORM:    osc_wave = v[wpo_pkg::WAVE_W-1:0];
            wpo_pkg::REG_PULSE_WIDTH: osc_pw   = v;
            default:                  osc_gain = v[wpo_pkg::AMP_W-1:0];
        endcase
        check_reg(r);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_access();
        for (int i = 0; i < 4; i++)
        begin
            check_reg(wpo_pkg::reg_idx_t'(i));
        end
    endtask

    task automatic test_table_modes();
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'h8000);
        for (int w = 0; w < 4; w++)
        begin
            write_reg(wpo_pkg::REG_WAVEFORM, 32'(w));
            load_and_tick((w % 2) ? 16'sh8000 : 16'sh7FFF);
        end
    endtask

    task automatic test_gain_saturation();
        write_reg(wpo_pkg::REG_WAVEFORM, 32'd0);
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'hFFFF);
        load_and_tick(16'sh8000);
        load_and_tick(16'sh7FFF);
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'd1);
        load_and_tick(-16'sd1);
    endtask

    task automatic test_square_mode();
        write_reg(wpo_pkg::REG_WAVEFORM, 32'(wpo_pkg::WAVE_SQUARE));
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'h8000);
        write_reg(wpo_pkg::REG_PULSE_WIDTH, 32'd0);
        play_tick();
        write_reg(wpo_pkg::REG_PULSE_WIDTH, 32'hFFFF_FFFF);
        play_tick();
        // phase equal to the pulse width sits on the high side
        write_reg(wpo_pkg::REG_PULSE_WIDTH, osc_phase);
        play_tick();
        write_reg(wpo_pkg::REG_PULSE_WIDTH, osc_phase + 32'd1);
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'hFFFF);
        play_tick();
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'd0);
        play_tick();
    endtask

    task automatic test_phase_wrap();
        write_reg(wpo_pkg::REG_WAVEFORM, 32'd0);
        write_reg(wpo_pkg::REG_AMPLITUDE, 32'h8000);
        write_reg(wpo_pkg::REG_PHASE_STEP, 32'hFFC0_0000 - osc_phase);
        play_tick();
        write_reg(wpo_pkg::REG_PHASE_STEP, 32'h0040_0000);
        load_and_tick(16'sh7FFF);
        play_tick();
        write_reg(wpo_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        play_tick();
    endtask

    task automatic test_unused_waveforms();
        for (int w = 5; w < 8; w++)
        begin
            write_reg(wpo_pkg::REG_WAVEFORM, 32'(w));
            play_tick();
        end
    endtask

    task automatic test_output_backpressure();
        quiesce();
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        repeat (24) play_tick();
    endtask

    task automatic randomise_config();
        logic [31:0] step_v;
        logic [31:0] pw_v;
        logic [31:0] gain_v;
        logic [31:0] wave_v;
        int          pick;
        case ($urandom_range(5))
            0:       step_v = 32'd0;
            1:       step_v = 32'hFFFF_FFFF;
            2:       step_v = 32'h8000_0000;
            3:       step_v = $urandom_range(32'h0080_0000);
            default: step_v = $urandom;
        endcase
        pick = $urandom_range(11);
        wave_v = (pick < 10) ? 32'(pick % 5) : 32'($urandom_range(7, 5));
        case ($urandom_range(3))
            0:       pw_v = 32'd0;
            1:       pw_v = 32'hFFFF_FFFF;
            default: pw_v = $urandom;
        endcase
        case ($urandom_range(5))
            0:       gain_v = 32'd0;
            1:       gain_v = 32'h8000;
            2:       gain_v = 32'hFFFF;
            3:       gain_v = 32'(16'($urandom));
            default: gain_v = $urandom_range(32768);
        endcase
        write_reg(wpo_pkg::REG_PHASE_STEP, step_v);
        write_reg(wpo_pkg::REG_WAVEFORM, wave_v);
        write_reg(wpo_pkg::REG_PULSE_WIDTH, pw_v);
        write_reg(wpo_pkg::REG_AMPLITUDE, gain_v);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            if (b == 3)
            begin
                set_profile(53, 36);
            end
            else if (b == 6)
            begin
                set_profile(0, 0);
            end
            randomise_config();
            target = items_sent + BLOCK_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 25)
                begin
                    send_item(wpo_pkg::ACT_LOAD, 2'($urandom), 10'($urandom),
                              16'($urandom));
                end
                else
                begin
                    play_tick();
                end
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        action       = wpo_pkg::ACT_TICK;
        table_select = '0;
        entry_index  = '0;
        entry_value  = '0;
        osc_step     = wpo_pkg::PHASE_STEP_RST;
        osc_wave     = wpo_pkg::WAVEFORM_RST;
        osc_pw       = wpo_pkg::PULSE_WIDTH_RST;
        osc_gain     = wpo_pkg::AMPLITUDE_RST;
        osc_phase    = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_profile(36, 53);

        test_register_access();
        test_table_modes();
        test_gain_saturation();
        test_square_mode();
        test_phase_wrap();
        test_unused_waveforms();
        test_output_backpressure();
        test_random_traffic();

        quiesce();
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
